/* hdl/uart_register_block_with_fifos_unit_defines.svh */
// assertion macros used by the uart register block executor
`ifndef UART_REGISTER_BLOCK_WITH_FIFOS_UNIT_DEFINES_SVH
`define UART_REGISTER_BLOCK_WITH_FIFOS_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define UARTRB_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("uartrb assertion failed");

// next-cycle implication, checked outside reset
`define UARTRB_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("uartrb assertion failed");

`endif

/* hdl/uartrb_pkg.sv */
// types, codes and constants of the uart register block
package uartrb_pkg;

   localparam int FIFO_DEPTH_DEF   = 8;
   localparam int REGION_BYTES_DEF = 4096;
   localparam int CMDQ_DEPTH       = 2;
   localparam int ADDR_W           = 12;
   localparam int DATA_W           = 32;
   localparam int BYTE_W           = 8;
   localparam int MARK_W           = 3;
   localparam int DIV_W            = 16;

   localparam logic [DATA_W-1:0] RD_FLAG      = 32'h8000_0000;
   localparam logic [DIV_W-1:0]  BAUD_DIV_RST = 16'hFFFF;

   // request kinds
   localparam logic [1:0] REQ_WRITE = 2'd0;
   localparam logic [1:0] REQ_READ  = 2'd1;
   localparam logic [1:0] REQ_RX    = 2'd2;

   // register offsets
   localparam logic [ADDR_W-1:0] ADDR_TXDATA = 12'h000;
   localparam logic [ADDR_W-1:0] ADDR_RXDATA = 12'h004;
   localparam logic [ADDR_W-1:0] ADDR_TXCTRL = 12'h008;
   localparam logic [ADDR_W-1:0] ADDR_RXCTRL = 12'h00C;
   localparam logic [ADDR_W-1:0] ADDR_IE     = 12'h010;
   localparam logic [ADDR_W-1:0] ADDR_IP     = 12'h014;
   localparam logic [ADDR_W-1:0] ADDR_DIV    = 12'h018;

   // result kinds
   localparam logic KIND_BUS = 1'b0;
   localparam logic KIND_TX  = 1'b1;

   typedef enum logic [1:0] {
      OP_RX_BYTE,
      OP_READ,
      OP_WRITE,
      OP_ERROR
   } uartrb_op_type;

   typedef enum logic [2:0] {
      REG_TXDATA,
      REG_RXDATA,
      REG_TXCTRL,
      REG_RXCTRL,
      REG_IE,
      REG_IP,
      REG_DIV,
      REG_NONE
   } uartrb_reg_type;

   typedef struct packed {
      logic [1:0]        req_type;
      logic [ADDR_W-1:0] address;
      logic [DATA_W-1:0] write_data;
      logic [BYTE_W-1:0] rx_byte;
   } uartrb_req_type;

   typedef struct packed {
      logic              item_kind;
      logic              bus_ok;
      logic [DATA_W-1:0] read_data;
      logic [BYTE_W-1:0] tx_byte;
      logic              last;
   } uartrb_rsp_type;

   typedef struct packed {
      uartrb_op_type     op;
      uartrb_reg_type    reg_sel;
      logic [DATA_W-1:0] data;
      logic [BYTE_W-1:0] rx_byte;
   } uartrb_cmd_type;

endpackage

/* hdl/uart_register_block_with_fifos_unit.sv */
// Bus register block of a UART with transmit and receive FIFOs. Requests (bus write, bus read,
// received byte) enter a two-entry command queue and are carried out one at a time by the
// executor, which passes from its idle state to its execute state for each. A bus write with
// transmit enabled then drains every byte of the transmit FIFO, each through a wait state for
// the registered read port of the FIFO memories and an output state. Results leave through a
// one-entry output register, waiting while it is full; a received byte gives no result.
module uart_register_block_with_fifos_unit #(
   parameter int FIFO_DEPTH   = uartrb_pkg::FIFO_DEPTH_DEF,
   parameter int REGION_BYTES = uartrb_pkg::REGION_BYTES_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_push,
   output logic                       req_full,
   input  uartrb_pkg::uartrb_req_type req_data,
   output logic                       rsp_empty,
   input  logic                       rsp_pop,
   output uartrb_pkg::uartrb_rsp_type rsp_data
);
   import uartrb_pkg::*;

   uartrb_cmd_type dec_cmd;
   logic           dec_keep;
   logic           q_push;
   logic           q_pop;
   logic           q_empty;
   uartrb_cmd_type q_data;

   assign q_push = req_push && !req_full && dec_keep;

   uartrb_front #(
      .REGION_BYTES(REGION_BYTES)
   ) u_front (
      .req_data(req_data),
      .cmd_data(dec_cmd),
      .cmd_keep(dec_keep)
   );

   uartrb_cmdq u_cmdq (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_data(dec_cmd),
      .full     (req_full),
      .pop      (q_pop),
      .pop_data (q_data),
      .empty    (q_empty)
   );

   uartrb_back #(
      .FIFO_DEPTH(FIFO_DEPTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cmd_empty(q_empty),
      .cmd_data (q_data),
      .cmd_pop  (q_pop),
      .rsp_empty(rsp_empty),
      .rsp_pop  (rsp_pop),
      .rsp_data (rsp_data)
   );

endmodule

/* hdl/uartrb_front.sv */
// request decoder: range and alignment checks, register selection
module uartrb_front #(
   parameter int REGION_BYTES = uartrb_pkg::REGION_BYTES_DEF
) (
   input  uartrb_pkg::uartrb_req_type req_data,
   output uartrb_pkg::uartrb_cmd_type cmd_data,
   output logic                       cmd_keep
);
   import uartrb_pkg::*;

   logic           in_range;
   logic           aligned;
   uartrb_reg_type reg_sel;

   assign in_range = ({1'b0, req_data.address} + (ADDR_W+1)'(4)) <= (ADDR_W+1)'(REGION_BYTES);
   assign aligned  = (req_data.address[1:0] == 2'b00);

   always_comb begin
      unique case (req_data.address)
         ADDR_TXDATA: reg_sel = REG_TXDATA;
         ADDR_RXDATA: reg_sel = REG_RXDATA;
         ADDR_TXCTRL: reg_sel = REG_TXCTRL;
         ADDR_RXCTRL: reg_sel = REG_RXCTRL;
         ADDR_IE:     reg_sel = REG_IE;
         ADDR_IP:     reg_sel = REG_IP;
         ADDR_DIV:    reg_sel = REG_DIV;
         default:     reg_sel = REG_NONE;
      endcase
   end

   always_comb begin
      cmd_data.reg_sel = reg_sel;
      cmd_data.data    = req_data.write_data;
      cmd_data.rx_byte = req_data.rx_byte;
      cmd_keep         = 1'b1;
      unique case (req_data.req_type)
         REQ_WRITE: cmd_data.op = in_range ? OP_WRITE : OP_ERROR;
         REQ_READ:  cmd_data.op = (in_range && aligned) ? OP_READ : OP_ERROR;
         REQ_RX:    cmd_data.op = OP_RX_BYTE;
         default: begin
            cmd_data.op = OP_ERROR;
            cmd_keep    = 1'b0;
         end
      endcase
   end

endmodule

/* hdl/uartrb_cmdq.sv */
// short command queue between decoder and executor
module uartrb_cmdq (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  uartrb_pkg::uartrb_cmd_type push_data,
   output logic                       full,
   input  logic                       pop,
   output uartrb_pkg::uartrb_cmd_type pop_data,
   output logic                       empty
);
   import uartrb_pkg::*;

   localparam int QPTR_W = $clog2(CMDQ_DEPTH);
   localparam int QCNT_W = $clog2(CMDQ_DEPTH + 1);

   uartrb_cmd_type    q_mem [CMDQ_DEPTH];
   logic [QPTR_W-1:0] wr_ff, wr_in;
   logic [QPTR_W-1:0] rd_ff, rd_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   logic              do_push;
   logic              do_pop;

   assign full     = (cnt_ff == QCNT_W'(CMDQ_DEPTH));
   assign empty    = (cnt_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = q_mem[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == QPTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == QPTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_mem[wr_ff] <= push_data;
      end
   end

endmodule

/* hdl/uartrb_back.sv */
// executor: register file, transmit and receive fifos, result register
`include "uart_register_block_with_fifos_unit_defines.svh"

module uartrb_back #(
   parameter int FIFO_DEPTH = uartrb_pkg::FIFO_DEPTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       cmd_empty,
   input  uartrb_pkg::uartrb_cmd_type cmd_data,
   output logic                       cmd_pop,
   output logic                       rsp_empty,
   input  logic                       rsp_pop,
   output uartrb_pkg::uartrb_rsp_type rsp_data
);
   import uartrb_pkg::*;

   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
   localparam int CMP_W = (CNT_W > MARK_W) ? CNT_W : MARK_W;

   localparam logic [1:0] ST_IDLE       = 2'd0;
   localparam logic [1:0] ST_EXEC       = 2'd1;
   localparam logic [1:0] ST_DRAIN_WAIT = 2'd2;
   localparam logic [1:0] ST_DRAIN_OUT  = 2'd3;

   function automatic logic [PTR_W-1:0] nxt(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   logic [BYTE_W-1:0] tx_mem [FIFO_DEPTH];
   logic [BYTE_W-1:0] rx_mem [FIFO_DEPTH];
   logic [BYTE_W-1:0] tx_rd_ff;
   logic [BYTE_W-1:0] rx_rd_ff;

   logic [1:0]        state_ff, state_in;
   uartrb_cmd_type    cmd_ff;
   logic [PTR_W-1:0]  tx_head_ff, tx_head_in, tx_tail_ff, tx_tail_in;
   logic [CNT_W-1:0]  tx_fill_ff, tx_fill_in;
   logic [PTR_W-1:0]  rx_head_ff, rx_head_in, rx_tail_ff, rx_tail_in;
   logic [CNT_W-1:0]  rx_fill_ff, rx_fill_in;
   logic              tx_on_ff, tx_on_in, two_stop_ff, two_stop_in;
   logic [MARK_W-1:0] tx_mark_ff, tx_mark_in, rx_mark_ff, rx_mark_in;
   logic              rx_on_ff, rx_on_in;
   logic              rx_int_en_ff, rx_int_en_in, tx_int_en_ff, tx_int_en_in;
   logic [DIV_W-1:0]  baud_div_ff, baud_div_in;
   logic              out_valid_ff, out_valid_in;
   uartrb_rsp_type    out_ff, out_in;

   logic              out_free;
   logic              out_load;
   logic              tx_we;
   logic              rx_we;
   logic              tx_full;
   logic              tx_gt;
   logic              rx_gt;
   logic [DATA_W-1:0] rd_val;

   assign out_free  = !out_valid_ff || rsp_pop;
   assign cmd_pop   = (state_ff == ST_IDLE) && !cmd_empty;
   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;
   assign tx_full   = (tx_fill_ff == CNT_W'(FIFO_DEPTH));
   assign tx_gt     = CMP_W'(tx_fill_ff) > CMP_W'(tx_mark_ff);
   assign rx_gt     = CMP_W'(rx_fill_ff) > CMP_W'(rx_mark_ff);

   always_comb begin
      unique case (cmd_ff.reg_sel)
         REG_TXDATA: rd_val = tx_full ? RD_FLAG : '0;
         REG_RXDATA: rd_val = (rx_fill_ff != '0) ? {24'b0, rx_rd_ff} : RD_FLAG;
         REG_TXCTRL: rd_val = {13'b0, tx_mark_ff, 14'b0, two_stop_ff, tx_on_ff};
         REG_RXCTRL: rd_val = {13'b0, rx_mark_ff, 15'b0, rx_on_ff};
         REG_IE:     rd_val = {30'b0, tx_int_en_ff, rx_int_en_ff};
         REG_IP:     rd_val = {30'b0, rx_gt, tx_gt};
         REG_DIV:    rd_val = {16'b0, baud_div_ff};
         default:    rd_val = '0;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      tx_head_in   = tx_head_ff;
      tx_tail_in   = tx_tail_ff;
      tx_fill_in   = tx_fill_ff;
      rx_head_in   = rx_head_ff;
      rx_tail_in   = rx_tail_ff;
      rx_fill_in   = rx_fill_ff;
      tx_on_in     = tx_on_ff;
      two_stop_in  = two_stop_ff;
      tx_mark_in   = tx_mark_ff;
      rx_on_in     = rx_on_ff;
      rx_mark_in   = rx_mark_ff;
      rx_int_en_in = rx_int_en_ff;
      tx_int_en_in = tx_int_en_ff;
      baud_div_in  = baud_div_ff;
      tx_we        = 1'b0;
      rx_we        = 1'b0;
      out_load     = 1'b0;
      out_in       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (!cmd_empty) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            unique case (cmd_ff.op)
               OP_RX_BYTE: begin
                  if (rx_on_ff && (rx_fill_ff != CNT_W'(FIFO_DEPTH))) begin
                     rx_we      = 1'b1;
                     rx_tail_in = nxt(rx_tail_ff);
                     rx_fill_in = rx_fill_ff + 1'b1;
                  end
                  state_in = ST_IDLE;
               end
               OP_ERROR: begin
                  if (out_free) begin
                     out_load       = 1'b1;
                     out_in.last    = 1'b1;
                     state_in       = ST_IDLE;
                  end
               end
               OP_READ: begin
                  if (out_free) begin
                     out_load         = 1'b1;
                     out_in.item_kind = KIND_BUS;
                     out_in.bus_ok    = 1'b1;
                     out_in.read_data = rd_val;
                     out_in.last      = 1'b1;
                     if ((cmd_ff.reg_sel == REG_RXDATA) && (rx_fill_ff != '0)) begin
                        rx_head_in = nxt(rx_head_ff);
                        rx_fill_in = rx_fill_ff - 1'b1;
                     end
                     state_in = ST_IDLE;
                  end
               end
               default: begin
                  if (out_free) begin
                     unique case (cmd_ff.reg_sel)
                        REG_TXDATA: begin
                           if (!tx_full) begin
                              tx_we      = 1'b1;
                              tx_tail_in = nxt(tx_tail_ff);
                              tx_fill_in = tx_fill_ff + 1'b1;
                           end
                        end
                        REG_TXCTRL: begin
                           tx_on_in    = cmd_ff.data[0];
                           two_stop_in = cmd_ff.data[1];
                           tx_mark_in  = cmd_ff.data[18:16];
                        end
                        REG_RXCTRL: begin
                           rx_on_in   = cmd_ff.data[0];
                           rx_mark_in = cmd_ff.data[18:16];
                        end
                        REG_IE: begin
                           rx_int_en_in = cmd_ff.data[0];
                           tx_int_en_in = cmd_ff.data[1];
                        end
                        REG_DIV: baud_div_in = cmd_ff.data[DIV_W-1:0];
                        default: ;
                     endcase
                     out_load         = 1'b1;
                     out_in.item_kind = KIND_BUS;
                     out_in.bus_ok    = 1'b1;
                     if (tx_on_in && (tx_fill_in != '0)) begin
                        out_in.last = 1'b0;
                        state_in    = ST_DRAIN_WAIT;
                     end else begin
                        out_in.last = 1'b1;
                        state_in    = ST_IDLE;
                     end
                  end
               end
            endcase
         end
         ST_DRAIN_WAIT: begin
            state_in = ST_DRAIN_OUT;
         end
         default: begin
            if (out_free) begin
               out_load         = 1'b1;
               out_in.item_kind = KIND_TX;
               out_in.tx_byte   = tx_rd_ff;
               out_in.last      = (tx_fill_ff == CNT_W'(1));
               tx_head_in       = nxt(tx_head_ff);
               tx_fill_in       = tx_fill_ff - 1'b1;
               state_in         = (tx_fill_ff == CNT_W'(1)) ? ST_IDLE : ST_DRAIN_WAIT;
            end
         end
      endcase
      out_valid_in = out_load ? 1'b1 : (rsp_pop ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tx_head_ff   <= '0;
         tx_tail_ff   <= '0;
         tx_fill_ff   <= '0;
         rx_head_ff   <= '0;
         rx_tail_ff   <= '0;
         rx_fill_ff   <= '0;
         tx_on_ff     <= 1'b0;
         two_stop_ff  <= 1'b0;
         tx_mark_ff   <= '0;
         rx_on_ff     <= 1'b0;
         rx_mark_ff   <= '0;
         rx_int_en_ff <= 1'b0;
         tx_int_en_ff <= 1'b0;
         baud_div_ff  <= BAUD_DIV_RST;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tx_head_ff   <= tx_head_in;
         tx_tail_ff   <= tx_tail_in;
         tx_fill_ff   <= tx_fill_in;
         rx_head_ff   <= rx_head_in;
         rx_tail_ff   <= rx_tail_in;
         rx_fill_ff   <= rx_fill_in;
         tx_on_ff     <= tx_on_in;
         two_stop_ff  <= two_stop_in;
         tx_mark_ff   <= tx_mark_in;
         rx_on_ff     <= rx_on_in;
         rx_mark_ff   <= rx_mark_in;
         rx_int_en_ff <= rx_int_en_in;
         tx_int_en_ff <= tx_int_en_in;
         baud_div_ff  <= baud_div_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         cmd_ff <= cmd_data;
      end
      if (out_load) begin
         out_ff <= out_in;
      end
   end

   // fifo storage, read data registered at the head pointer
   always_ff @(posedge clock) begin
      if (tx_we) begin
         tx_mem[tx_tail_ff] <= cmd_ff.data[BYTE_W-1:0];
      end
      tx_rd_ff <= tx_mem[tx_head_ff];
   end

   always_ff @(posedge clock) begin
      if (rx_we) begin
         rx_mem[rx_tail_ff] <= cmd_ff.rx_byte;
      end
      rx_rd_ff <= rx_mem[rx_head_ff];
   end

   `UARTRB_ASSERT_IMP(a_drain_nonempty, clock, reset, (state_ff == ST_DRAIN_OUT), (tx_fill_ff != '0))
   `UARTRB_ASSERT_NXT(a_more_follows, clock, reset, (out_load && !out_in.last), (state_ff == ST_DRAIN_WAIT))
   `UARTRB_ASSERT_IMP(a_rx_pop_nonempty, clock, reset, (rx_head_in != rx_head_ff), (rx_fill_ff != '0))
   `UARTRB_ASSERT_IMP(a_no_overwrite, clock, reset, out_load, out_free)

endmodule

/* tb/sv/testbench.sv */
// self-checking testbench for the uart register block with transmit and receive fifos
`timescale 1ns / 100ps

module testbench;
   import uartrb_pkg::*;

   localparam logic [1:0] REQ_IGNORED = 2'd3;

   logic           clock;
   logic           reset;
   logic           req_push;
   logic           req_full;
   uartrb_req_type req_data;
   logic           rsp_empty;
   logic           rsp_pop;
   uartrb_rsp_type rsp_data;

   uart_register_block_with_fifos_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   // predicted uart state
   logic [BYTE_W-1:0] txq_bytes[FIFO_DEPTH_DEF];
   logic [BYTE_W-1:0] rxq_bytes[FIFO_DEPTH_DEF];
   int                txq_rd = 0, txq_wr = 0, txq_count = 0;
   int                rxq_rd = 0, rxq_wr = 0, rxq_count = 0;
   logic              tx_active = 1'b0, tx_two_stop = 1'b0, rx_active = 1'b0;
   logic [MARK_W-1:0] tx_level = '0, rx_level = '0;
   logic              irq_en_rx = 1'b0, irq_en_tx = 1'b0;
   logic [DIV_W-1:0]  divisor = BAUD_DIV_RST;

   uartrb_rsp_type    awaited_results[$];
   uartrb_rsp_type    want;
   int                error_count = 0;
   int                sent_count = 0;
   int                send_idle_pct = 0;
   int                pop_stall_pct = 0;
   int                hold_off_cycles = 0;
   int                drain_wait;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2ms;
      $display("== FAIL ==");
      $finish;
   end

   task automatic flag_error(input string msg);
      if (error_count < 40) $display("ERROR at %0t: %s", $time, msg);
      error_count++;
   endtask

   task automatic predict_uart_results(input uartrb_req_type r);
      uartrb_rsp_type    item;
      logic [DATA_W-1:0] value;
      bit                in_range;
      in_range = (int'(r.address) + 4 <= REGION_BYTES_DEF);
      item = '0;
      item.item_kind = KIND_BUS;
      item.last = 1'b1;
      value = '0;
      case (r.req_type)
         REQ_RX: begin
            if (rx_active && rxq_count < FIFO_DEPTH_DEF) begin
               rxq_bytes[rxq_wr] = r.rx_byte;
               rxq_wr = (rxq_wr + 1) % FIFO_DEPTH_DEF;
               rxq_count++;
            end
         end
         REQ_READ: begin
            if (r.address[1:0] != 2'b00 || !in_range) begin
               item.bus_ok = 1'b0;
            end else begin
               item.bus_ok = 1'b1;
               case (r.address)
                  ADDR_TXDATA: value = (txq_count >= FIFO_DEPTH_DEF) ? RD_FLAG : '0;
                  ADDR_RXDATA: begin
                     if (rxq_count > 0) begin
                        value = {24'b0, rxq_bytes[rxq_rd]};
                        rxq_rd = (rxq_rd + 1) % FIFO_DEPTH_DEF;
                        rxq_count--;
                     end else begin
                        value = RD_FLAG;
                     end
                  end
                  ADDR_TXCTRL: value = {13'b0, tx_level, 14'b0, tx_two_stop, tx_active};
                  ADDR_RXCTRL: value = {13'b0, rx_level, 15'b0, rx_active};
                  ADDR_IE:     value = {30'b0, irq_en_tx, irq_en_rx};
                  ADDR_IP:     value = {30'b0, rxq_count > rx_level,
                                        txq_count > tx_level};
                  ADDR_DIV:    value = {16'b0, divisor};
                  default:     value = '0;
               endcase
            end
            item.read_data = value;
            awaited_results.push_back(item);
         end
         REQ_WRITE: begin
            if (!in_range) begin
               item.bus_ok = 1'b0;
               awaited_results.push_back(item);
            end else begin
               case (r.address)
                  ADDR_TXDATA: begin
                     if (txq_count < FIFO_DEPTH_DEF) begin
                        txq_bytes[txq_wr] = r.write_data[7:0];
                        txq_wr = (txq_wr + 1) % FIFO_DEPTH_DEF;
                        txq_count++;
                     end
                  end
                  ADDR_TXCTRL: begin
                     tx_active = r.write_data[0];
                     tx_two_stop = r.write_data[1];
                     tx_level = r.write_data[18:16];
                  end
                  ADDR_RXCTRL: begin
                     rx_active = r.write_data[0];
                     rx_level = r.write_data[18:16];
                  end
                  ADDR_IE: begin
                     irq_en_rx = r.write_data[0];
                     irq_en_tx = r.write_data[1];
                  end
                  ADDR_DIV: divisor = r.write_data[15:0];
                  default: ;
               endcase
               item.bus_ok = 1'b1;
               item.last = !(tx_active && txq_count > 0);
               awaited_results.push_back(item);
               while (tx_active && txq_count > 0) begin
                  item = '0;
                  item.item_kind = KIND_TX;
                  item.tx_byte = txq_bytes[txq_rd];
                  txq_rd = (txq_rd + 1) % FIFO_DEPTH_DEF;
                  txq_count--;
                  item.last = (txq_count == 0);
                  awaited_results.push_back(item);
               end
            end
         end
         default: ;
      endcase
   endtask

   task automatic send_request(input uartrb_req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_full !== 1'b0);
      predict_uart_results(r);
      if (r.req_type != REQ_IGNORED) sent_count++;
   endtask

   function automatic uartrb_req_type make_req(input logic [1:0] kind,
                                               input logic [ADDR_W-1:0] addr,
                                               input logic [DATA_W-1:0] data,
                                               input logic [BYTE_W-1:0] rbyte);
      uartrb_req_type r;
      r.req_type = kind;
      r.address = addr;
      r.write_data = data;
      r.rx_byte = rbyte;
      return r;
   endfunction

   task automatic do_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
      send_request(make_req(REQ_WRITE, addr, data, BYTE_W'($urandom_range(255))));
   endtask

   task automatic do_read(input logic [ADDR_W-1:0] addr);
      send_request(make_req(REQ_READ, addr, $urandom(), BYTE_W'($urandom_range(255))));
   endtask

   task automatic do_rx(input logic [BYTE_W-1:0] rbyte);
      send_request(make_req(REQ_RX, ADDR_W'($urandom_range(4095)), $urandom(), rbyte));
   endtask

   function automatic logic [ADDR_W-1:0] pick_address();
      logic [ADDR_W-1:0] mapped[8];
      mapped = '{ADDR_TXDATA, ADDR_RXDATA, ADDR_TXCTRL, ADDR_RXCTRL,
                 ADDR_IE, ADDR_IP, ADDR_DIV, 12'h01C};
      case ($urandom_range(9))
         7: return ADDR_W'($urandom_range(31));
         8, 9: return ADDR_W'($urandom_range(4095));
         default: return mapped[$urandom_range(7)];
      endcase
   endfunction

   // receiver: random stalls plus an optional long hold-off
   always @(posedge clock) begin
      if (hold_off_cycles > 0) begin
         rsp_pop <= 1'b0;
         hold_off_cycles--;
      end else begin
         rsp_pop <= ($urandom_range(99) >= pop_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_pop === 1'b1 && rsp_empty === 1'b0) begin
         if (awaited_results.size() == 0) begin
            flag_error($sformatf("unexpected result %h", rsp_data));
         end else begin
            want = awaited_results.pop_front();
            if (rsp_data.item_kind !== want.item_kind)
               flag_error($sformatf("item_kind %b, want %b", rsp_data.item_kind,
                                    want.item_kind));
            if (rsp_data.bus_ok !== want.bus_ok)
               flag_error($sformatf("bus_ok %b, want %b", rsp_data.bus_ok, want.bus_ok));
            if (rsp_data.read_data !== want.read_data)
               flag_error($sformatf("read_data %h, want %h", rsp_data.read_data,
                                    want.read_data));
            if (rsp_data.tx_byte !== want.tx_byte)
               flag_error($sformatf("tx_byte %h, want %h", rsp_data.tx_byte, want.tx_byte));
            if (rsp_data.last !== want.last)
               flag_error($sformatf("last %b, want %b", rsp_data.last, want.last));
         end
      end
   end

   task automatic test_reset_values;
      do_read(ADDR_DIV);
      do_read(ADDR_TXCTRL);
      do_read(ADDR_IP);
      // receive still disabled, byte is dropped
      do_rx(8'hA5);
      do_read(ADDR_RXDATA);
   endtask

   task automatic test_register_extremes;
      do_write(ADDR_TXCTRL, 32'hFFFF_FFFF);
      do_write(ADDR_RXCTRL, 32'hFFFF_FFFF);
      do_write(ADDR_IE, 32'hFFFF_FFFF);
      do_write(ADDR_DIV, 32'h0000_0000);
      do_read(ADDR_TXCTRL);
      do_read(ADDR_RXCTRL);
      do_read(ADDR_IE);
      do_read(ADDR_DIV);
      do_write(ADDR_TXCTRL, 32'h0000_0000);
   endtask

   task automatic test_bus_errors;
      do_read(12'hFFD);
      do_read(12'hFFC);
      do_write(12'hFFF, 32'hFFFF_FFFF);
      do_read(12'h00A);
      do_write(12'h009, 32'hFFFF_FFFF);
      do_write(ADDR_IP, 32'hFFFF_FFFF);
      do_write(ADDR_RXDATA, 32'hFFFF_FFFF);
      send_request(make_req(REQ_IGNORED, ADDR_TXDATA, 32'hFFFF_FFFF, 8'hFF));
   endtask

   task automatic test_transmit_fifo;
      // one more byte than fits, the last is dropped
      for (int i = 0; i <= FIFO_DEPTH_DEF; i++)
         do_write(ADDR_TXDATA, (i % 2) ? 32'hFFFF_FFFF : 32'h0000_0000);
      do_read(ADDR_TXDATA);
      do_read(ADDR_IP);
      do_write(ADDR_TXCTRL, 32'h0000_0001);
   endtask

   task automatic test_backpressure;
      send_idle_pct = 0;
      pop_stall_pct = 0;
      hold_off_cycles = 400;
      do_write(ADDR_RXCTRL, 32'h0003_0001);
      for (int i = 0; i < FIFO_DEPTH_DEF + 2; i++)
         do_rx(BYTE_W'($urandom_range(255)));
      repeat (FIFO_DEPTH_DEF + 4) do_read(ADDR_RXDATA);
   endtask

   task automatic run_random_sequence;
      int n;
      case ($urandom_range(9))
         0, 1, 2: begin
            do_write(ADDR_TXCTRL, $urandom() & ~32'h1);
            n = $urandom_range(1, FIFO_DEPTH_DEF + 2);
            repeat (n) do_write(ADDR_TXDATA, $urandom());
            if ($urandom_range(1)) do_read(ADDR_TXDATA);
            do_read(ADDR_IP);
            do_write(ADDR_TXCTRL, $urandom() | 32'h1);
         end
         3, 4, 5: begin
            do_write(ADDR_RXCTRL, ($urandom_range(5) == 0) ? ($urandom() & ~32'h1)
                                                            : ($urandom() | 32'h1));
            n = $urandom_range(1, FIFO_DEPTH_DEF + 2);
            repeat (n) do_rx(BYTE_W'($urandom_range(255)));
            do_read(ADDR_IP);
            n = $urandom_range(1, FIFO_DEPTH_DEF + 2);
            repeat (n) do_read(ADDR_RXDATA);
         end
         6, 7: begin
            case ($urandom_range(3))
               0: begin
                  do_write(ADDR_TXCTRL, $urandom());
                  do_read(ADDR_TXCTRL);
               end
               1: begin
                  do_write(ADDR_RXCTRL, $urandom());
                  do_read(ADDR_RXCTRL);
               end
               2: begin
                  do_write(ADDR_IE, $urandom());
                  do_read(ADDR_IE);
               end
               default: begin
                  do_write(ADDR_DIV, $urandom());
                  do_read(ADDR_DIV);
               end
            endcase
         end
         default: begin
            repeat ($urandom_range(1, 4))
               send_request(make_req(2'($urandom_range(3)), pick_address(), $urandom(),
                                     BYTE_W'($urandom_range(255))));
         end
      endcase
   endtask

   task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                      input int count);
      int goal;
      goal = sent_count + count;
      send_idle_pct = idle_pct;
      pop_stall_pct = stall_pct;
      while (sent_count < goal) run_random_sequence();
   endtask

   initial begin
      reset = 1'b1;
      req_push = 1'b0;
      req_data = '0;
      rsp_pop = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_reset_values();
      test_register_extremes();
      test_bus_errors();
      test_transmit_fifo();
      test_backpressure();
      test_random_traffic(0, 0, 35);
      test_random_traffic(53, 0, 35);
      test_random_traffic(0, 53, 35);
      test_random_traffic(10, 10, 35);

      req_push <= 1'b0;
      pop_stall_pct = 0;
      drain_wait = 0;
      while (awaited_results.size() != 0 && drain_wait < 20000) begin
         @(posedge clock);
         drain_wait++;
      end
      repeat (40) @(posedge clock);
      if (awaited_results.size() != 0)
         flag_error($sformatf("%0d results never arrived", awaited_results.size()));

      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

/* filelist.f */
+incdir+hdl
hdl/uartrb_pkg.sv
hdl/uartrb_front.sv
hdl/uartrb_cmdq.sv
hdl/uartrb_back.sv
hdl/uart_register_block_with_fifos_unit.sv
tb/sv/testbench.sv
